[hdl/cpc_pkg.sv]
// shared types, constants and helpers for the contact penetration correction block
package cpc_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned NrmW   = 18;
  localparam int unsigned ValW   = 32;
  localparam int unsigned RemW   = 38;
  localparam int unsigned MulAW  = 33;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned FracW  = 16;
  localparam int unsigned Lanes  = 3;

  typedef enum logic [1:0] {
    MUL_DOT = 2'd0,
    MUL_UPD = 2'd1,
    MUL_SQ  = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     in_ready;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     load_rem;
    logic     acc_en;
    logic     load_out;
    logic     clr_corr;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic rem_pos;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic signed [ValW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'(64'sd2147483647);
    lo = ProdW'(-64'sd2147483648);
    if (v > hi) begin
      sat32 = {1'b0, {(ValW-1){1'b1}}};
    end else if (v < lo) begin
      sat32 = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      sat32 = v[ValW-1:0];
    end
  endfunction

  function automatic logic [ValW-1:0] abs32(input logic signed [ValW-1:0] v);
    logic [ValW-1:0] neg;
    neg = ValW'(-v);
    abs32 = v[ValW-1] ? neg : v;
  endfunction

endpackage

[hdl/cpc_item_if.sv]
// valid/ready channel carrying one contact word
interface cpc_item_if;
  logic                               valid;
  logic                               ready;
  logic        [cpc_pkg::IdW-1:0]     entity_id;
  logic signed [cpc_pkg::NrmW-1:0]    normal_x;
  logic signed [cpc_pkg::NrmW-1:0]    normal_y;
  logic signed [cpc_pkg::NrmW-1:0]    normal_z;
  logic signed [cpc_pkg::ValW-1:0]    penetration;
  logic signed [cpc_pkg::ValW-1:0]    pos_x;
  logic signed [cpc_pkg::ValW-1:0]    pos_y;
  logic signed [cpc_pkg::ValW-1:0]    pos_z;
  logic                               last_contact;

  modport source (
    output valid, entity_id, normal_x, normal_y, normal_z, penetration,
           pos_x, pos_y, pos_z, last_contact,
    input  ready
  );
  modport sink (
    input  valid, entity_id, normal_x, normal_y, normal_z, penetration,
           pos_x, pos_y, pos_z, last_contact,
    output ready
  );
endinterface

[hdl/cpc_result_if.sv]
// valid/ready channel carrying one corrected position word
interface cpc_result_if;
  logic                               valid;
  logic                               ready;
  logic        [cpc_pkg::IdW-1:0]     out_entity_id;
  logic signed [cpc_pkg::ValW-1:0]    new_pos_x;
  logic signed [cpc_pkg::ValW-1:0]    new_pos_y;
  logic signed [cpc_pkg::ValW-1:0]    new_pos_z;
  logic                               moved;

  modport source (
    output valid, out_entity_id, new_pos_x, new_pos_y, new_pos_z, moved,
    input  ready
  );
  modport sink (
    input  valid, out_entity_id, new_pos_x, new_pos_y, new_pos_z, moved,
    output ready
  );
endinterface

[hdl/cpc_ctrl.sv]
// sequencing state machine for the correction datapath
module cpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cpc_pkg::status_t  status_i,
  output cpc_pkg::cmd_t     cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DOT  = 7'b0000010,
    ST_REM  = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_ACC  = 7'b0010000,
    ST_SQ   = 7'b0100000,
    ST_CMP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.mul_sel   = cpc_pkg::MUL_DOT;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          state_d = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpc_pkg::MUL_DOT;
        state_d       = ST_REM;
      end
      ST_REM: begin
        cmd_o.load_rem = 1'b1;
        state_d        = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpc_pkg::MUL_UPD;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = status_i.rem_pos;
        state_d      = status_i.last ? ST_SQ : ST_IDLE;
      end
      ST_SQ: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cpc_pkg::MUL_SQ;
        state_d       = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.clr_corr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/cpc_datapath.sv]
// correction registers, three multiplier lanes, threshold and output register
module cpc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cpc_pkg::ValW-1:0]     cfg_wdata_i,
  cpc_item_if.sink                     item_i,
  cpc_result_if.source                 result_o,
  input  cpc_pkg::cmd_t                cmd_i,
  output cpc_pkg::status_t             status_o
);

  localparam int unsigned L   = cpc_pkg::Lanes;
  localparam int unsigned VW  = cpc_pkg::ValW;
  localparam int unsigned PW  = cpc_pkg::ProdW;
  localparam int unsigned AW  = cpc_pkg::MulAW;
  localparam int unsigned RW  = cpc_pkg::RemW;
  localparam int unsigned FW  = cpc_pkg::FracW;
  localparam int unsigned NW  = cpc_pkg::NrmW;

  logic                          load_in;
  logic [VW-1:0]                 thr_q;
  logic [cpc_pkg::IdW-1:0]       id_q;
  logic signed [NW-1:0]          nrm_q  [L];
  logic signed [VW-1:0]          pos_q  [L];
  logic signed [VW-1:0]          pen_q;
  logic                          last_q;
  logic signed [VW-1:0]          corr_q [L];
  logic signed [PW-1:0]          prod_q [L];
  logic signed [RW-1:0]          rem_q;
  logic signed [PW-1:0]          dot_sum;
  logic signed [PW-1:0]          rem_full;
  logic [PW-1:0]                 len_sq;
  logic                          moved;
  logic signed [VW-1:0]          new_pos [L];
  logic                          out_valid_q;
  logic [cpc_pkg::IdW-1:0]       out_id_q;
  logic signed [VW-1:0]          out_pos_q [L];
  logic                          out_moved_q;

  assign load_in      = cmd_i.in_ready && item_i.valid;
  assign item_i.ready = cmd_i.in_ready;

  assign status_o.in_valid = item_i.valid;
  assign status_o.rem_pos  = !rem_q[RW-1] && (|rem_q);
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      id_q     <= item_i.entity_id;
      nrm_q[0] <= item_i.normal_x;
      nrm_q[1] <= item_i.normal_y;
      nrm_q[2] <= item_i.normal_z;
      pos_q[0] <= item_i.pos_x;
      pos_q[1] <= item_i.pos_y;
      pos_q[2] <= item_i.pos_z;
      pen_q    <= item_i.penetration;
      last_q   <= item_i.last_contact;
    end
  end

  // remaining = penetration - floor(dot / 2^16)
  assign dot_sum  = prod_q[0] + prod_q[1] + prod_q[2];
  assign rem_full = PW'(pen_q) - (dot_sum >>> FW);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rem) begin
      rem_q <= rem_full[RW-1:0];
    end
  end

  for (genvar k = 0; k < L; k++) begin : g_lane
    logic signed [AW-1:0]    mul_a;
    logic signed [RW-1:0]    mul_b;
    logic signed [AW+RW-1:0] mul_full;
    logic [VW-1:0]           mag;
    logic signed [PW-1:0]    acc_sum;

    assign mag = cpc_pkg::abs32(corr_q[k]);

    always_comb begin
      case (cmd_i.mul_sel)
        cpc_pkg::MUL_DOT: begin
          mul_a = AW'(corr_q[k]);
          mul_b = RW'(nrm_q[k]);
        end
        cpc_pkg::MUL_UPD: begin
          mul_a = AW'(nrm_q[k]);
          mul_b = rem_q;
        end
        cpc_pkg::MUL_SQ: begin
          mul_a = {1'b0, mag};
          mul_b = {{(RW-VW){1'b0}}, mag};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end

    assign mul_full = mul_a * mul_b;
    assign acc_sum  = PW'(corr_q[k]) + (prod_q[k] >>> FW);
    assign new_pos[k] = moved ? cpc_pkg::sat32(PW'(pos_q[k]) + PW'(corr_q[k])) : pos_q[k];

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_en) begin
        prod_q[k] <= mul_full[PW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        corr_q[k] <= '0;
      end else if (cmd_i.clr_corr) begin
        corr_q[k] <= '0;
      end else if (cmd_i.acc_en) begin
        corr_q[k] <= cpc_pkg::sat32(acc_sum);
      end
    end
  end

  // squared length, exact unsigned q32.32
  assign len_sq = prod_q[0] + prod_q[1] + prod_q[2];
  assign moved  = len_sq > {{(PW-VW){1'b0}}, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_id_q     <= id_q;
      out_pos_q[0] <= new_pos[0];
      out_pos_q[1] <= new_pos[1];
      out_pos_q[2] <= new_pos[2];
      out_moved_q  <= moved;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.out_entity_id = out_id_q;
  assign result_o.new_pos_x     = out_pos_q[0];
  assign result_o.new_pos_y     = out_pos_q[1];
  assign result_o.new_pos_z     = out_pos_q[2];
  assign result_o.moved         = out_moved_q;

endmodule

[hdl/contact_penetration_correction.sv]
// Contact penetration correction, top level. Contacts of one entity arrive in a row;
// the block takes one contact word at a time and holds a Q16.16 correction vector.
// Each contact passes the states DOT, REM, UPD and ACC before the next can be accepted; a
// last contact also passes SQ and CMP, where its result is loaded into the output register,
// and CMP waits while the output register is still full. The sequence follows from
// the three multiplier lanes, which are shared in turn by the dot product,
// the scaling by the remaining depth and the squared length. The output register
// lets the next contact enter while a result waits. The user must write the threshold
// through cfg_we_i/cfg_wdata_i only while the block is idle; the block does not check.
module contact_penetration_correction (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cpc_pkg::ValW-1:0]  cfg_wdata_i,
  cpc_item_if.sink                  item_i,
  cpc_result_if.source              result_o
);

  cpc_pkg::cmd_t    cmd;
  cpc_pkg::status_t status;

  cpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cpc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .result_o    (result_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // a result is only written into a free output slot
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.out_free)
    else $error("result written over a pending word");

  // busy for the cycle after a contact is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("contact accepted back to back");

  // a loaded result shows up as valid next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> result_o.valid)
    else $error("loaded result not presented");

  // correction is cleared only together with a result
  a_clear_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_corr |-> cmd.load_out)
    else $error("correction cleared without result");

endmodule
